FILE: src/blf_pkg.sv
// Shared types and constants of the Blowfish cipher engine.
// No dependencies; blf_ctrl, blf_datapath and the top level import this package.
package blf_pkg;

  localparam int WORD_W      = 32;
  localparam int IDX_W       = 10;
  localparam int P_DEPTH     = 18;
  localparam int P_IDX_W     = 5;
  localparam int S_BOXES     = 4;
  localparam int S_DEPTH     = 256;
  localparam int S_ADDR_W    = 8;
  localparam int ROUNDS_DEF  = 16;

  typedef enum logic [1:0] {
    REQ_WR_P = 2'd0,
    REQ_WR_S = 2'd1,
    REQ_ENC  = 2'd2,
    REQ_DEC  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYMIX,
    ST_FEISTEL,
    ST_WHITE_R,
    ST_WHITE_L
  } state_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic               load;
    logic               keymix;
    logic               feistel;
    logic               white_r;
    logic               white_l;
    logic [P_IDX_W-1:0] p_sel;
  } ctrl_t;

endpackage

FILE: src/blf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/blf_ctrl.sv
// Round sequencer: walks key mix / Feistel steps, then output whitening.
// Depends on blf_pkg.
module blf_ctrl #(
  parameter int ROUNDS = blf_pkg::ROUNDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          decrypt,
  input  logic          out_free,
  output logic          idle,
  output blf_pkg::ctrl_t ctrl
);
  import blf_pkg::*;

  localparam int RND_W = $clog2(ROUNDS);

  state_t           state, state_next;
  logic [RND_W-1:0] rnd;
  logic             dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rnd <= '0;
      dec <= decrypt;
    end else if (state == ST_FEISTEL) begin
      rnd <= rnd + RND_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_KEYMIX;
      ST_KEYMIX:  state_next = ST_FEISTEL;
      ST_FEISTEL: begin
        if (rnd == RND_W'(ROUNDS - 1)) state_next = ST_WHITE_R;
        else                           state_next = ST_KEYMIX;
      end
      ST_WHITE_R: state_next = ST_WHITE_L;
      ST_WHITE_L: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.load  = start;
    idle       = 1'b0;
    unique case (state)
      ST_IDLE:    idle = 1'b1;
      ST_KEYMIX: begin
        ctrl.keymix = 1'b1;
        // decryption walks P from the top down
        ctrl.p_sel  = dec ? (P_IDX_W'(ROUNDS + 1) - P_IDX_W'(rnd)) : P_IDX_W'(rnd);
      end
      ST_FEISTEL: ctrl.feistel = 1'b1;
      ST_WHITE_R: begin
        ctrl.white_r = 1'b1;
        ctrl.p_sel   = dec ? P_IDX_W'(1) : P_IDX_W'(ROUNDS);
      end
      ST_WHITE_L: begin
        ctrl.white_l = out_free;
        ctrl.p_sel   = dec ? P_IDX_W'(0) : P_IDX_W'(ROUNDS + 1);
      end
      default: ;
    endcase
  end

endmodule

FILE: src/blf_datapath.sv
// Block halves, P array and the shared round-function unit.
// Depends on blf_pkg; S-box words come from the RAMs in the top level.
module blf_datapath (
  input  logic                                              clk,
  input  blf_pkg::ctrl_t                                    ctrl,
  input  logic [blf_pkg::WORD_W-1:0]                        block_left,
  input  logic [blf_pkg::WORD_W-1:0]                        block_right,
  input  logic                                              p_we,
  input  logic [blf_pkg::P_IDX_W-1:0]                       p_idx,
  input  logic [blf_pkg::WORD_W-1:0]                        p_word,
  input  logic [blf_pkg::S_BOXES-1:0][blf_pkg::WORD_W-1:0]  s_data,
  output logic [blf_pkg::S_BOXES-1:0][blf_pkg::S_ADDR_W-1:0] s_addr,
  output logic [blf_pkg::WORD_W-1:0]                        res_left,
  output logic [blf_pkg::WORD_W-1:0]                        res_right
);
  import blf_pkg::*;

  logic [WORD_W-1:0] p_array [P_DEPTH];
  logic [WORD_W-1:0] xl, xr, white_r;
  logic [WORD_W-1:0] p_word_rd, xl_mix, f_val;

  function automatic logic [P_IDX_W-1:0] p_sel_idx(input logic [P_IDX_W-1:0] sel);
    return sel;
  endfunction

  always_ff @(posedge clk) begin
    if (p_we) begin
      p_array[p_idx] <= p_word;
    end
  end

  assign p_word_rd = p_array[p_sel_idx(ctrl.p_sel)];
  assign xl_mix    = xl ^ p_word_rd;

  // S-box read addresses: most significant byte goes to box 0
  always_comb begin
    for (int i = 0; i < S_BOXES; i++) begin
      s_addr[i] = xl_mix[WORD_W-1-8*i -: 8];
    end
  end

  assign f_val = ((s_data[0] + s_data[1]) ^ s_data[2]) + s_data[3];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      xl <= block_left;
      xr <= block_right;
    end else if (ctrl.keymix) begin
      xl <= xl_mix;
    end else if (ctrl.feistel) begin
      xl <= xr ^ f_val;
      xr <= xl;
    end
    if (ctrl.white_r) begin
      white_r <= xl ^ p_word_rd;
    end
  end

  // final swap is folded in: left result comes from xr
  assign res_left  = xr ^ p_word_rd;
  assign res_right = white_r;

endmodule

FILE: src/blowfish_block_cipher.sv
// Blowfish engine top level: input decode, S-box RAMs, sequencer, output register.
// Depends on blf_pkg, blf_ram, blf_ctrl, blf_datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | req_type, table_index, table_word, block_left/right
//  out     | out_valid/out_ready | out_left, out_right
//
// A table write is taken on its handshake and gives no result.
// A cipher item runs ROUNDS rounds from accept to result:
// each round is a key-mix step that issues the four S-box reads and a Feistel
// step that uses the registered RAM data, then the right and left whitening steps.
// in_ready is low while a block is in flight; a result waiting in the output
// register does not block new items, but the next result waits for it.
// Reset clears control only; table contents are undefined until written.
module blowfish_block_cipher #(
  parameter int ROUNDS = blf_pkg::ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [blf_pkg::IDX_W-1:0]   table_index,
  input  logic [blf_pkg::WORD_W-1:0]  table_word,
  input  logic [blf_pkg::WORD_W-1:0]  block_left,
  input  logic [blf_pkg::WORD_W-1:0]  block_right,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [blf_pkg::WORD_W-1:0]  out_left,
  output logic [blf_pkg::WORD_W-1:0]  out_right
);
  import blf_pkg::*;

  logic   accept, start, decrypt, out_free, idle, p_we;
  req_t   req;
  ctrl_t  ctrl;
  logic [S_BOXES-1:0][WORD_W-1:0]   s_data;
  logic [S_BOXES-1:0][S_ADDR_W-1:0] s_addr;
  logic [WORD_W-1:0] res_left, res_right;

  assign req      = req_t'(req_type);
  assign in_ready = idle && !rst;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (req == REQ_ENC || req == REQ_DEC);
  assign decrypt  = (req == REQ_DEC);
  // P writes past the last word are dropped
  assign p_we     = accept && (req == REQ_WR_P) && (table_index < IDX_W'(P_DEPTH));
  assign out_free = !out_valid || out_ready;

  for (genvar g = 0; g < S_BOXES; g++) begin : g_sbox
    blf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (S_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (accept && (req == REQ_WR_S) && (table_index[IDX_W-1 -: 2] == 2'(g))),
      .waddr (table_index[S_ADDR_W-1:0]),
      .wdata (table_word),
      .raddr (s_addr[g]),
      .rdata (s_data[g])
    );
  end

  blf_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .decrypt  (decrypt),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  blf_datapath u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .block_left  (block_left),
    .block_right (block_right),
    .p_we        (p_we),
    .p_idx       (table_index[P_IDX_W-1:0]),
    .p_word      (table_word),
    .s_data      (s_data),
    .s_addr      (s_addr),
    .res_left    (res_left),
    .res_right   (res_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.white_l) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.white_l) begin
      out_left  <= res_left;
      out_right <= res_right;
    end
  end

endmodule
